/* hw/rtl/bvdm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvdm_pkg
// Types, codes and constants shared by the valve duty mapper modules.
// ----------------------------------------------------------------------------
package bvdm_pkg;

	localparam int LOG_TABLE_DEPTH_DEF = 256;

	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam longint unsigned LN2_Q30 = 64'd744261118;

	localparam int DIV_NUM_W = 33;
	localparam int DIV_DEN_W = 16;

	localparam logic [2:0] STAT_VALVE_ONE = 3'd0;
	localparam logic [2:0] STAT_VALVE_TWO = 3'd1;
	localparam logic [2:0] STAT_DEAD_ZONE = 3'd2;
	localparam logic [2:0] STAT_DISABLED  = 3'd3;
	localparam logic [2:0] STAT_FAULT     = 3'd4;

	typedef enum logic [2:0] {
		CFG_DEAD_ZONE  = 3'd0,
		CFG_MIN_DUTY   = 3'd1,
		CFG_END_POINT  = 3'd2,
		CFG_MAX_DUTY   = 3'd3,
		CFG_RAMP       = 3'd4,
		CFG_REST_FRAC  = 3'd5,
		CFG_SLEW_LIMIT = 3'd6,
		CFG_ALPHA      = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		logic [15:0] sample;
		logic        sample_fault;
		logic        enable;
	} in_item_t;

	typedef struct packed {
		logic [14:0] duty_first;
		logic [14:0] duty_second;
		logic        relay_on;
		logic [2:0]  status;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SLEW,
		OP_EMA_MUL,
		OP_EMA_ADD,
		OP_CLASS,
		OP_LNORM,
		OP_LIDX,
		OP_LDIF,
		OP_LINT,
		OP_EMUL,
		OP_EIDX,
		OP_EDIF,
		OP_EINT,
		OP_LINE,
		OP_DIVGO,
		OP_DUTY,
		OP_DUTY_MAX,
		OP_REST,
		OP_FIN
	} op_e;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SLEW,
		ST_EMA_MUL,
		ST_EMA_ADD,
		ST_CLASS,
		ST_LNORM,
		ST_LIDX,
		ST_LDIF,
		ST_LINT,
		ST_EMUL,
		ST_EIDX,
		ST_EDIF,
		ST_EINT,
		ST_LINE,
		ST_DIVGO,
		ST_DIVW,
		ST_DUTY,
		ST_DUTY_MAX,
		ST_REST,
		ST_FIN
	} state_t;

	typedef struct packed {
		op_e op;
	} cmd_t;

	typedef struct packed {
		logic fault;
		logic rest_sel;
		logic degenerate;
		logic pow_trivial;
		logic k_big;
		logic div_done;
	} dp_status_t;

endpackage

/* hw/rtl/bvdm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvdm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvdm_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bvdm_pkg::DIV_NUM_W-1:0] num,
	input  logic [bvdm_pkg::DIV_DEN_W-1:0] den,
	output logic                           done,
	output logic [bvdm_pkg::DIV_NUM_W-1:0] quo
);
	import bvdm_pkg::*;

	localparam int CW = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= num;
			rem_q  <= '0;
			den_q  <= den;
			cnt_q  <= CW'(DIV_NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[DIV_NUM_W-2:0], fits};
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

/* hw/rtl/bvdm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvdm_datapath
// Configuration, filter state, power curve, line mapping and output register.
// ----------------------------------------------------------------------------
module bvdm_datapath #(
	parameter int LOG_TABLE_DEPTH = bvdm_pkg::LOG_TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bvdm_pkg::cmd_t        cmd,
	input  bvdm_pkg::in_item_t    in_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [15:0]           cfg_wdata,
	output bvdm_pkg::dp_status_t  st,
	output bvdm_pkg::out_item_t   out_item
);
	import bvdm_pkg::*;

	localparam int IW = $clog2(LOG_TABLE_DEPTH + 1);
	localparam logic [IW-1:0] DEPTH_C = IW'(LOG_TABLE_DEPTH);

	typedef logic [16:0] tab_t [0:LOG_TABLE_DEPTH];

	// log2(1+i/D) in Q16 by repeated squaring
	function automatic tab_t build_log();
		tab_t tab;
		longint unsigned y;
		longint unsigned acc;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			acc = 0;
			if (i == LOG_TABLE_DEPTH) begin
				acc = 64'd65536;
			end else begin
				y = ONE_Q30 + (longint'(i) * ONE_Q30) / LOG_TABLE_DEPTH;
				for (int b = 0; b < 16; b++) begin
					y = (y * y) >> 30;
					acc = acc << 1;
					if (y >= 2 * ONE_Q30) begin
						acc = acc | 64'd1;
						y = y >> 1;
					end
				end
			end
			tab[i] = acc[16:0];
		end
		return tab;
	endfunction

	// 2^(-j/D) in Q16 by Taylor series
	function automatic tab_t build_exp();
		tab_t tab;
		longint unsigned u;
		longint unsigned term;
		longint unsigned rnd;
		longint sum;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			u = (longint'(i) * LN2_Q30) / LOG_TABLE_DEPTH;
			term = ONE_Q30;
			sum = longint'(ONE_Q30);
			for (longint unsigned K = 1; K <= 15; K++) begin
				term = ((term * u) >> 30) / K;
				if (K[0]) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			rnd = (longint'(sum) + 64'd8192) >> 14;
			tab[i] = rnd[16:0];
		end
		return tab;
	endfunction

	localparam tab_t LOG_TAB = build_log();
	localparam tab_t EXP_TAB = build_exp();

	// configuration
	logic [15:0] dead_zone_q, end_point_q, rest_frac_q, slew_limit_q, alpha_q;
	logic [13:0] min_duty_q;
	logic [14:0] max_duty_q;
	logic [10:0] ramp_q;

	// item and filter state
	logic [15:0] sample_q;
	logic        fault_q, enable_q;
	logic [15:0] slewed_q, smoothed_q;
	logic [14:0] held_first_q, held_second_q;
	logic        held_relay_q;
	logic [2:0]  stat_q;
	out_item_t   out_q;

	// working registers
	logic [31:0]    ema_prod_q;
	logic           ema_neg_q;
	logic [16:0]    mag_q;
	logic [14:0]    rest_q;
	logic [4:0]     e_q;
	logic [15:0]    f_q;
	logic [IW-1:0]  i_q;
	logic [15:0]    fr_q;
	logic [16:0]    ta_q, td_q;
	logic [20:0]    n_q;
	logic [24:0]    m_q;
	logic [4:0]     k_q;
	logic [16:0]    p_q;
	logic [33:0]    prod_q;

	// combinational
	logic signed [17:0] slew_d, slew_lim;
	logic [15:0]        slew_next;
	logic [16:0]        ema_diff;
	logic [15:0]        ema_abs;
	logic [32:0]        ema_round;
	logic signed [17:0] x_s, dz_s;
	logic               cls_ge, cls_le;
	logic [2:0]         cls;
	logic [17:0]        mag_neg;
	logic [16:0]        mag_w;
	logic [30:0]        rest_w;
	logic [4:0]         e_w;
	logic [16:0]        norm_sh;
	logic [15:0]        frac_in;
	logic [15+IW:0]     idx_prod;
	logic [IW-1:0]      i_nx;
	logic [32:0]        interp_p;
	logic [16:0]        interp_hi;
	logic [17:0]        lf_w;
	logic [32:0]        m_w;
	logic signed [15:0] line_a;
	logic signed [17:0] line_b;
	logic signed [33:0] line_p;
	logic [32:0]        prod_abs;
	logic [15:0]        den_w;
	logic [32:0]        div_num;
	logic               div_done;
	logic [32:0]        div_quo;
	logic signed [34:0] duty_s;
	logic [14:0]        duty_c;

	assign slew_d   = $signed({2'b00, sample_q}) - $signed({2'b00, slewed_q});
	assign slew_lim = $signed({2'b00, slew_limit_q});

	always_comb begin
		if (slew_d > slew_lim) begin
			slew_next = slewed_q + slew_limit_q;
		end else if (slew_d < -slew_lim) begin
			slew_next = slewed_q - slew_limit_q;
		end else begin
			slew_next = sample_q;
		end
	end

	assign ema_diff  = {1'b0, slewed_q} - {1'b0, smoothed_q};
	assign ema_abs   = ema_diff[16] ? 16'(-ema_diff) : ema_diff[15:0];
	assign ema_round = {1'b0, ema_prod_q} + 33'd32768;

	assign x_s    = $signed({1'b0, smoothed_q, 1'b0}) - 18'sd65536;
	assign dz_s   = $signed({2'b00, dead_zone_q});
	assign cls_ge = x_s >= dz_s;
	assign cls_le = x_s <= -dz_s;
	assign mag_neg = 18'(-x_s);
	assign mag_w  = cls_ge ? x_s[16:0] : mag_neg[16:0];
	assign rest_w = 31'(min_duty_q) * 31'(rest_frac_q) + 31'd32768;

	always_comb begin
		if (!(cls_ge || cls_le)) cls = STAT_DEAD_ZONE;
		else if (!enable_q) cls = STAT_DISABLED;
		else if (cls_ge) cls = STAT_VALVE_ONE;
		else cls = STAT_VALVE_TWO;
	end

	always_comb begin
		e_w = '0;
		for (int b = 0; b < 17; b++) begin
			if (mag_q[b]) e_w = 5'(b);
		end
	end

	assign norm_sh  = mag_q << (5'd16 - e_w);
	assign frac_in  = (cmd.op == OP_EIDX) ? m_q[15:0] : f_q;
	assign idx_prod = (16 + IW)'(frac_in) * (16 + IW)'(DEPTH_C);
	assign i_nx     = i_q + IW'(1);
	assign interp_p = 33'(td_q) * 33'(fr_q);
	assign interp_hi = interp_p[32:16];
	assign lf_w     = 18'(ta_q) + 18'(interp_hi);
	assign m_w      = 33'(32'(n_q) * 32'(ramp_q)) + 33'd128;

	assign line_a   = $signed({1'b0, max_duty_q}) - $signed({2'b00, min_duty_q});
	assign line_b   = $signed({1'b0, p_q}) - $signed({2'b00, dead_zone_q});
	assign line_p   = 34'(line_a) * 34'(line_b);
	assign prod_abs = prod_q[33] ? 33'(-prod_q) : prod_q[32:0];
	assign den_w    = end_point_q - dead_zone_q;
	assign div_num  = prod_abs + 33'(den_w[15:1]);

	bvdm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIVGO),
		.num    (div_num),
		.den    (den_w),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		if (cmd.op == OP_DUTY_MAX) begin
			duty_s = 35'(max_duty_q);
		end else if (prod_q[33]) begin
			duty_s = $signed({21'b0, min_duty_q}) - $signed({2'b00, div_quo});
		end else begin
			duty_s = $signed({21'b0, min_duty_q}) + $signed({2'b00, div_quo});
		end
		if (duty_s > $signed({20'b0, max_duty_q})) duty_c = max_duty_q;
		else if (duty_s < 0) duty_c = '0;
		else duty_c = duty_s[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q  <= '0;
			min_duty_q   <= '0;
			end_point_q  <= 16'd32768;
			max_duty_q   <= 15'd12800;
			ramp_q       <= 11'd256;
			rest_frac_q  <= '0;
			slew_limit_q <= 16'd6554;
			alpha_q      <= 16'd6554;
		end else if (cfg_we) begin
			unique case (cfg_idx_e'(cfg_idx))
				CFG_DEAD_ZONE:  dead_zone_q  <= cfg_wdata;
				CFG_MIN_DUTY:   min_duty_q   <= cfg_wdata[13:0];
				CFG_END_POINT:  end_point_q  <= cfg_wdata;
				CFG_MAX_DUTY:   max_duty_q   <= cfg_wdata[14:0];
				CFG_RAMP:       ramp_q       <= cfg_wdata[10:0];
				CFG_REST_FRAC:  rest_frac_q  <= cfg_wdata;
				CFG_SLEW_LIMIT: slew_limit_q <= cfg_wdata;
				CFG_ALPHA:      alpha_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q      <= '0;
			fault_q       <= 1'b0;
			enable_q      <= 1'b0;
			slewed_q      <= '0;
			smoothed_q    <= '0;
			held_first_q  <= '0;
			held_second_q <= '0;
			held_relay_q  <= 1'b0;
			stat_q        <= '0;
			out_q         <= '0;
			ema_prod_q    <= '0;
			ema_neg_q     <= 1'b0;
			mag_q         <= '0;
			rest_q        <= '0;
			e_q           <= '0;
			f_q           <= '0;
			i_q           <= '0;
			fr_q          <= '0;
			ta_q          <= '0;
			td_q          <= '0;
			n_q           <= '0;
			m_q           <= '0;
			k_q           <= '0;
			p_q           <= '0;
			prod_q        <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					sample_q <= in_item.sample;
					fault_q  <= in_item.sample_fault;
					enable_q <= in_item.enable;
					if (in_item.sample_fault) stat_q <= STAT_FAULT;
				end
				OP_SLEW: slewed_q <= slew_next;
				OP_EMA_MUL: begin
					ema_prod_q <= 32'(ema_abs) * 32'(alpha_q);
					ema_neg_q  <= ema_diff[16];
				end
				OP_EMA_ADD: begin
					if (ema_neg_q) smoothed_q <= smoothed_q - ema_round[31:16];
					else smoothed_q <= smoothed_q + ema_round[31:16];
				end
				OP_CLASS: begin
					stat_q <= cls;
					mag_q  <= mag_w;
					rest_q <= rest_w[30:16];
				end
				OP_LNORM: begin
					if (ramp_q == '0) p_q <= 17'd65536;
					else p_q <= '0;
					e_q <= e_w;
					f_q <= norm_sh[15:0];
				end
				OP_LIDX, OP_EIDX: begin
					i_q  <= idx_prod[15+IW:16];
					fr_q <= idx_prod[15:0];
					k_q  <= m_q[20:16];
					p_q  <= '0;
				end
				OP_LDIF: begin
					ta_q <= LOG_TAB[i_q];
					td_q <= LOG_TAB[i_nx] - LOG_TAB[i_q];
				end
				OP_LINT: n_q <= {5'd16 - e_q, 16'b0} - 21'(lf_w);
				OP_EMUL: m_q <= m_w[32:8];
				OP_EDIF: begin
					ta_q <= EXP_TAB[i_q];
					td_q <= EXP_TAB[i_q] - EXP_TAB[i_nx];
				end
				OP_EINT: p_q <= (ta_q - interp_hi) >> k_q;
				OP_LINE: prod_q <= line_p;
				OP_DUTY, OP_DUTY_MAX: begin
					if (stat_q == STAT_VALVE_ONE) begin
						held_first_q  <= duty_c;
						held_second_q <= rest_q;
					end else begin
						held_first_q  <= rest_q;
						held_second_q <= duty_c;
					end
					held_relay_q <= 1'b1;
				end
				OP_REST: begin
					held_first_q  <= rest_q;
					held_second_q <= rest_q;
					held_relay_q  <= 1'b0;
				end
				OP_FIN: begin
					out_q.duty_first  <= held_first_q;
					out_q.duty_second <= held_second_q;
					out_q.relay_on    <= held_relay_q;
					out_q.status      <= stat_q;
				end
				default: ;
			endcase
		end
	end

	assign st.fault       = fault_q;
	assign st.rest_sel    = !(cls_ge || cls_le) || !enable_q;
	assign st.degenerate  = end_point_q <= dead_zone_q;
	assign st.pow_trivial = (ramp_q == '0) || (mag_q == '0);
	assign st.k_big       = m_q[24:16] > 9'd16;
	assign st.div_done    = div_done;
	assign out_item       = out_q;

endmodule

/* hw/rtl/bvdm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvdm_ctrl
// Sequencer: steps one item through the datapath and runs both handshakes.
// ----------------------------------------------------------------------------
module bvdm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bvdm_pkg::dp_status_t st,
	output bvdm_pkg::cmd_t       cmd
);
	import bvdm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		fin     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SLEW;
				end
			end
			ST_SLEW: begin
				if (st.fault) begin
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_SLEW;
					state_d = ST_EMA_MUL;
				end
			end
			ST_EMA_MUL: begin
				cmd.op  = OP_EMA_MUL;
				state_d = ST_EMA_ADD;
			end
			ST_EMA_ADD: begin
				cmd.op  = OP_EMA_ADD;
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				cmd.op = OP_CLASS;
				priority if (st.rest_sel) state_d = ST_REST;
				else if (st.degenerate) state_d = ST_DUTY_MAX;
				else state_d = ST_LNORM;
			end
			ST_LNORM: begin
				cmd.op  = OP_LNORM;
				state_d = st.pow_trivial ? ST_LINE : ST_LIDX;
			end
			ST_LIDX: begin
				cmd.op  = OP_LIDX;
				state_d = ST_LDIF;
			end
			ST_LDIF: begin
				cmd.op  = OP_LDIF;
				state_d = ST_LINT;
			end
			ST_LINT: begin
				cmd.op  = OP_LINT;
				state_d = ST_EMUL;
			end
			ST_EMUL: begin
				cmd.op  = OP_EMUL;
				state_d = ST_EIDX;
			end
			ST_EIDX: begin
				cmd.op  = OP_EIDX;
				state_d = st.k_big ? ST_LINE : ST_EDIF;
			end
			ST_EDIF: begin
				cmd.op  = OP_EDIF;
				state_d = ST_EINT;
			end
			ST_EINT: begin
				cmd.op  = OP_EINT;
				state_d = ST_LINE;
			end
			ST_LINE: begin
				cmd.op  = OP_LINE;
				state_d = ST_DIVGO;
			end
			ST_DIVGO: begin
				cmd.op  = OP_DIVGO;
				state_d = ST_DIVW;
			end
			ST_DIVW: begin
				if (st.div_done) state_d = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.op  = OP_DUTY;
				state_d = ST_FIN;
			end
			ST_DUTY_MAX: begin
				cmd.op  = OP_DUTY_MAX;
				state_d = ST_FIN;
			end
			ST_REST: begin
				cmd.op  = OP_REST;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_FIN;
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/bidirectional_valve_duty_mapper.sv */
`timescale 1ns / 1ps
// Path per item: a faulty item skips the filter and goes straight to the
// result; dead zone or disabled items stop after the classification; the
// longest path runs the power curve and the bit-serial line division.
// Throughput: one item at a time; the next item is taken in the cycle after
// the result enters the output register. Reset clears all state and loads
// the configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
// bidirectional_valve_duty_mapper
// Joystick sample to two valve duties and a relay, via slew limit, EMA,
// dead zone, power curve and linear duty mapping.
// ----------------------------------------------------------------------------
module bidirectional_valve_duty_mapper #(
	parameter int LOG_TABLE_DEPTH = bvdm_pkg::LOG_TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bvdm_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bvdm_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata
);
	import bvdm_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	bvdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bvdm_datapath #(
		.LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.st        (st),
		.out_item  (out_item)
	);

endmodule
